// ===== hdl/ewds_pkg.sv =====
// shared types and constants for the encoder window direction and speed block
package ewds_pkg;

    // fixed field widths
    localparam int FIELD_W   = 10;
    localparam int SCALE_W   = 32;
    localparam int REG_IDX_W = 2;

    // register reset values
    localparam logic [FIELD_W-1:0] WINDOW_LENGTH_RST       = 10'd280;
    localparam logic [FIELD_W-1:0] DIRECTION_THRESHOLD_RST = 10'd14;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST         = 32'd15000000;

    // divider runs one quotient bit per cycle
    localparam int DIV_STEPS = SCALE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WINDOW_LENGTH       = 2'd0,
        REG_DIRECTION_THRESHOLD = 2'd1,
        REG_SPEED_SCALE         = 2'd2
    } reg_index_t;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic step;       // sample transaction accepted
        logic div_start;  // window closed, load divider
        logic div_run;    // one divider iteration
        logic load_out;   // last iteration, fill output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic win_end;    // next sample closes the window
        logic out_full;   // output register still holds a result
    } dp_status_t;

endpackage

// ===== hdl/ewds_channels.sv =====
// channel interfaces for samples, results and configuration writes
interface ewds_sample_if;
    logic valid;
    logic ready;
    logic chan_a;
    logic chan_b;

    modport source (output valid, output chan_a, output chan_b, input ready);
    modport sink (input valid, input chan_a, input chan_b, output ready);
endinterface

interface ewds_result_if;
    logic                          valid;
    logic                          ready;
    logic                          direction;
    logic [ewds_pkg::FIELD_W-1:0]  max_lag;
    logic [ewds_pkg::FIELD_W-1:0]  period_ticks;
    logic [ewds_pkg::SCALE_W-1:0]  speed;
    logic                          speed_valid;

    modport source (output valid, output direction, output max_lag, output period_ticks,
                    output speed, output speed_valid, input ready);
    modport sink (input valid, input direction, input max_lag, input period_ticks,
                  input speed, input speed_valid, output ready);
endinterface

interface ewds_cfg_if;
    logic                           valid;
    logic                           ready;
    ewds_pkg::reg_index_t           index;
    logic [ewds_pkg::SCALE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ewds_ctrl.sv =====
// controller: sample acceptance and divide sequencing
module ewds_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   smp_valid,
    output logic                   smp_ready,
    input  ewds_pkg::dp_status_t   status,
    output ewds_pkg::ctrl_cmd_t    cmd
);

    ewds_pkg::ctrl_state_t             state_reg, state_next;
    logic [ewds_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ewds_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        smp_ready  = 1'b0;
        case (state_reg)
            ewds_pkg::ST_IDLE:
            begin
                // closing sample waits until the previous result is taken
                smp_ready = !(status.win_end && status.out_full);
                cmd.step  = smp_valid && smp_ready;
                if (cmd.step && status.win_end)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ewds_pkg::ST_DIVIDE;
                end
            end
            ewds_pkg::ST_DIVIDE:
            begin
                cmd.div_run = 1'b1;
                if (cnt_reg == ewds_pkg::DIV_CNT_W'(ewds_pkg::DIV_STEPS - 1))
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ewds_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ewds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ewds_dp.sv =====
// datapath: window state, config registers, divider and output register
module ewds_dp #(
    parameter int INDEX_WIDTH = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   chan_a,
    input  logic                   chan_b,
    input  ewds_pkg::ctrl_cmd_t    cmd,
    output ewds_pkg::dp_status_t   status,
    ewds_cfg_if.sink               cfg,
    ewds_result_if.source          results
);

    localparam int FW    = ewds_pkg::FIELD_W;
    localparam int SW    = ewds_pkg::SCALE_W;
    localparam int CMP_W = ((INDEX_WIDTH > FW) ? INDEX_WIDTH : FW) + 1;

    // config registers
    logic [FW-1:0] window_length_reg;
    logic [FW-1:0] direction_threshold_reg;
    logic [SW-1:0] speed_scale_reg;

    // window state
    logic                   last_a_reg, last_a_next;
    logic                   last_b_reg, last_b_next;
    logic                   waiting_reg, waiting_next;
    logic [INDEX_WIDTH-1:0] lag_count_reg, lag_count_next;
    logic [INDEX_WIDTH-1:0] lag_max_reg, lag_max_next;
    logic [INDEX_WIDTH-1:0] sample_index_reg, sample_index_next;
    logic [INDEX_WIDTH-1:0] first_fall_reg, first_fall_next;
    logic [INDEX_WIDTH-1:0] second_fall_reg, second_fall_next;
    logic [1:0]             falls_reg, falls_next;
    logic                   lag_active;

    // window summary held during the divide
    logic                   res_dir_reg;
    logic [INDEX_WIDTH-1:0] res_lag_reg;
    logic [INDEX_WIDTH-1:0] res_period_reg;
    logic                   res_valid_reg;
    logic                   win_valid;

    // restoring divider
    logic [INDEX_WIDTH-1:0] rem_reg;
    logic [SW-1:0]          quo_reg;
    logic [INDEX_WIDTH:0]   rem_shift;
    logic                   rem_ge;
    logic [INDEX_WIDTH-1:0] rem_step;
    logic [SW-1:0]          quo_step;

    logic out_valid_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg       <= ewds_pkg::WINDOW_LENGTH_RST;
            direction_threshold_reg <= ewds_pkg::DIRECTION_THRESHOLD_RST;
            speed_scale_reg         <= ewds_pkg::SPEED_SCALE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ewds_pkg::REG_WINDOW_LENGTH:       window_length_reg <= cfg.data[FW-1:0];
                ewds_pkg::REG_DIRECTION_THRESHOLD: direction_threshold_reg <= cfg.data[FW-1:0];
                ewds_pkg::REG_SPEED_SCALE:         speed_scale_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // window closes once index + 1 reaches the length or the index is full
    assign status.win_end = !(((CMP_W'(sample_index_reg) + CMP_W'(1)) < CMP_W'(window_length_reg))
                              && (sample_index_reg != '1));
    assign status.out_full = out_valid_reg;

    always_comb
    begin
        last_a_next       = chan_a;
        last_b_next       = chan_b;
        waiting_next      = waiting_reg;
        lag_count_next    = lag_count_reg;
        lag_max_next      = lag_max_reg;
        first_fall_next   = first_fall_reg;
        second_fall_next  = second_fall_reg;
        falls_next        = falls_reg;
        sample_index_next = sample_index_reg + 1'b1;

        lag_active = waiting_reg || (!last_a_reg && chan_a);
        if (lag_active)
        begin
            if (chan_b)
            begin
                if (lag_count_reg > lag_max_reg)
                begin
                    lag_max_next = lag_count_reg;
                end
                lag_count_next = '0;
                waiting_next   = 1'b0;
            end
            else
            begin
                if (lag_count_reg != '1)
                begin
                    lag_count_next = lag_count_reg + 1'b1;
                end
                waiting_next = 1'b1;
            end
        end

        if (!chan_b && last_b_reg)
        begin
            if (falls_reg == 2'd0)
            begin
                first_fall_next = sample_index_reg;
                falls_next      = 2'd1;
            end
            else if (falls_reg == 2'd1)
            begin
                second_fall_next = sample_index_reg;
                falls_next       = 2'd2;
            end
        end
        win_valid = (falls_next == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg       <= 1'b1;
            last_b_reg       <= 1'b0;
            waiting_reg      <= 1'b0;
            lag_count_reg    <= '0;
            lag_max_reg      <= '0;
            sample_index_reg <= '0;
            first_fall_reg   <= '0;
            second_fall_reg  <= '0;
            falls_reg        <= '0;
        end
        else if (cmd.step)
        begin
            if (status.win_end)
            begin
                last_a_reg       <= 1'b1;
                last_b_reg       <= 1'b0;
                waiting_reg      <= 1'b0;
                lag_count_reg    <= '0;
                lag_max_reg      <= '0;
                sample_index_reg <= '0;
                first_fall_reg   <= '0;
                second_fall_reg  <= '0;
                falls_reg        <= '0;
            end
            else
            begin
                last_a_reg       <= last_a_next;
                last_b_reg       <= last_b_next;
                waiting_reg      <= waiting_next;
                lag_count_reg    <= lag_count_next;
                lag_max_reg      <= lag_max_next;
                sample_index_reg <= sample_index_next;
                first_fall_reg   <= first_fall_next;
                second_fall_reg  <= second_fall_next;
                falls_reg        <= falls_next;
            end
        end
    end

    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign rem_ge    = rem_shift >= {1'b0, res_period_reg};
    assign rem_step  = rem_ge ? INDEX_WIDTH'(rem_shift - {1'b0, res_period_reg})
                              : rem_shift[INDEX_WIDTH-1:0];
    assign quo_step  = {quo_reg[SW-2:0], rem_ge};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            res_dir_reg    <= CMP_W'(lag_max_next) > CMP_W'(direction_threshold_reg);
            res_lag_reg    <= lag_max_next;
            res_valid_reg  <= win_valid;
            res_period_reg <= win_valid ? (second_fall_next - first_fall_next) : '0;
            rem_reg        <= '0;
            quo_reg        <= speed_scale_reg;
        end
        else if (cmd.div_run)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            results.direction    <= res_dir_reg;
            results.max_lag      <= FW'(res_lag_reg);
            results.period_ticks <= FW'(res_period_reg);
            results.speed_valid  <= res_valid_reg;
            results.speed        <= (res_valid_reg && (res_period_reg != '0)) ? quo_step : '0;
        end
    end

    assign results.valid = out_valid_reg;

endmodule

// ===== hdl/encoder_window_direction_speed.sv =====
// top level of the encoder window direction and speed block
//
// channel   role    payload                                            handshake
// samples   sink    chan_a, chan_b                                     valid / ready
// results   source  direction, max_lag, period_ticks, speed, speed_valid  valid / ready
// cfg       sink    index, data                                        valid / ready
//
// the window's closing sample starts a restoring divide of speed_scale by the
// B period, one quotient bit per cycle, and the result is registered as the
// last quotient bit is formed
// samples are refused during that divide, and a closing sample also waits
// while the previous result has not been taken
// reset clears the window state and loads the register defaults
module encoder_window_direction_speed #(
    parameter int INDEX_WIDTH = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    ewds_sample_if.sink    samples,
    ewds_result_if.source  results,
    ewds_cfg_if.sink       cfg
);

    // command and status between controller and datapath
    ewds_pkg::ctrl_cmd_t   cmd;
    ewds_pkg::dp_status_t  status;
    logic                  smp_ready;

    assign samples.ready = smp_ready;

    // sequencing: sample acceptance, divide iteration count
    ewds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (samples.valid),
        .smp_ready (smp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // lag and edge tracking, config registers, divider, result register
    ewds_dp #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .chan_a  (samples.chan_a),
        .chan_b  (samples.chan_b),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .results (results)
    );

endmodule

// ===== hdl/ewds_checker.sv =====
// port-level checker for the encoder window block and its bind
module ewds_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          smp_valid,
    input logic                          smp_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          direction,
    input logic [ewds_pkg::FIELD_W-1:0]  max_lag,
    input logic [ewds_pkg::FIELD_W-1:0]  period_ticks,
    input logic [ewds_pkg::SCALE_W-1:0]  speed,
    input logic                          speed_valid
);

    // a result that is not taken stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // without two falls there is no period and no speed, with them a nonzero period
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !speed_valid |-> (period_ticks == '0) && (speed == '0))
        else $error("invalid period carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && speed_valid |-> period_ticks != '0)
        else $error("valid period is zero");

    // direction set means the largest lag exceeded some threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && direction |-> max_lag != '0)
        else $error("direction set with zero lag");

    // a result never follows a sample transaction in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready |=> !$rose(res_valid))
        else $error("result too soon after sample");

endmodule

bind encoder_window_direction_speed ewds_checker u_ewds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .smp_valid    (samples.valid),
    .smp_ready    (samples.ready),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .direction    (results.direction),
    .max_lag      (results.max_lag),
    .period_ticks (results.period_ticks),
    .speed        (results.speed),
    .speed_valid  (results.speed_valid)
);
